// File: hdl/cms_pkg.sv
// Shared types and constants for the chiller mode sequencer.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_PRECOOL = 2'd2,
    MODE_RUN     = 2'd3
  } mode_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_MIN_TEMPERATURE  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_RUN_TIME_MS      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_STANDBY_TIME_MS  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS_MS    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_PUMP_DUTY        = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_ROTATION_DUTY    = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_COOLER_FULL_DUTY = 3'd6;

  localparam logic signed [12:0] RST_MIN_TEMPERATURE  = 13'sd32;
  localparam logic [15:0]        RST_RUN_TIME_MS      = 16'd60000;
  localparam logic [15:0]        RST_STANDBY_TIME_MS  = 16'd30000;
  localparam logic [15:0]        RST_LONG_PRESS_MS    = 16'd3000;
  localparam logic [11:0]        RST_PUMP_DUTY        = 12'd2000;
  localparam logic [11:0]        RST_ROTATION_DUTY    = 12'd2000;
  localparam logic [11:0]        RST_COOLER_FULL_DUTY = 12'd4095;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [12:0] min_temperature;
    logic [15:0]        run_time_ms;
    logic [15:0]        standby_time_ms;
    logic [15:0]        long_press_ms;
    logic [11:0]        pump_duty;
    logic [11:0]        rotation_duty;
    logic [11:0]        cooler_full_duty;
  } cfg_t;

  typedef struct packed {
    logic signed [12:0] temperature;
    logic               button_level;
  } in_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic [11:0] pump_level;
    logic [11:0] rotation_level;
    logic [11:0] cooler_level;
    logic [15:0] remaining_ms;
    logic [15:0] cycles_done;
    logic        sleep_request;
  } out_t;

endpackage

`default_nettype wire

// File: hdl/cms_cfg_regs.sv
// Configuration register bank for the chiller mode sequencer.
// Depends on cms_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module cms_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [cms_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [cms_pkg::CfgDataWidth-1:0]      cfg_data,
  output cms_pkg::cfg_t                              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_temperature  <= cms_pkg::RST_MIN_TEMPERATURE;
      cfg.run_time_ms      <= cms_pkg::RST_RUN_TIME_MS;
      cfg.standby_time_ms  <= cms_pkg::RST_STANDBY_TIME_MS;
      cfg.long_press_ms    <= cms_pkg::RST_LONG_PRESS_MS;
      cfg.pump_duty        <= cms_pkg::RST_PUMP_DUTY;
      cfg.rotation_duty    <= cms_pkg::RST_ROTATION_DUTY;
      cfg.cooler_full_duty <= cms_pkg::RST_COOLER_FULL_DUTY;
    end else if (cfg_we) begin
      case (cfg_index)
        cms_pkg::REG_MIN_TEMPERATURE:  cfg.min_temperature  <= $signed(cfg_data[12:0]);
        cms_pkg::REG_RUN_TIME_MS:      cfg.run_time_ms      <= cfg_data;
        cms_pkg::REG_STANDBY_TIME_MS:  cfg.standby_time_ms  <= cfg_data;
        cms_pkg::REG_LONG_PRESS_MS:    cfg.long_press_ms    <= cfg_data;
        cms_pkg::REG_PUMP_DUTY:        cfg.pump_duty        <= cfg_data[11:0];
        cms_pkg::REG_ROTATION_DUTY:    cfg.rotation_duty    <= cfg_data[11:0];
        cms_pkg::REG_COOLER_FULL_DUTY: cfg.cooler_full_duty <= cfg_data[11:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/cms_core.sv
// Mode state machine, elapsed timer, press latch and run counter.
// Depends on cms_pkg (mode_t, cfg_t, in_t, out_t).
`timescale 1ns / 1ps
`default_nettype none

module cms_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire cms_pkg::cfg_t cfg,
  input  wire cms_pkg::in_t  in_data,
  output cms_pkg::out_t      result,
  output cms_pkg::mode_t     mode
);

  cms_pkg::mode_t mode_next;
  logic [15:0]    elapsed_ms, elapsed_ms_next;
  logic           press_latch, press_latch_next;
  logic [15:0]    cycle_count, cycle_count_next;

  logic        warm;
  logic        standby_timeout;
  logic        latch_set;
  logic        latch_eff;
  logic [15:0] press_time;
  logic        short_press;
  logic        long_press;
  logic        run_active;
  logic        restart;

  // Decode shared by next-state and output logic
  assign warm            = in_data.temperature >= cfg.min_temperature;
  assign standby_timeout = elapsed_ms >= cfg.standby_time_ms;
  assign latch_set       = in_data.button_level && !press_latch;
  assign latch_eff       = press_latch || in_data.button_level;
  // a fresh latch restarts the timer before the press is judged
  assign press_time      = latch_set ? 16'd0 : elapsed_ms;
  assign short_press     = !in_data.button_level && press_latch
                           && (elapsed_ms < cfg.long_press_ms);
  assign long_press      = in_data.button_level && latch_eff
                           && (press_time >= cfg.long_press_ms);
  assign run_active      = elapsed_ms < cfg.run_time_ms;

  // Next state
  always_comb begin
    mode_next        = mode;
    press_latch_next = press_latch;
    cycle_count_next = cycle_count;
    restart          = 1'b0;
    case (mode)
      cms_pkg::MODE_OFF: ;
      cms_pkg::MODE_STANDBY: begin
        if (in_data.button_level) begin
          mode_next        = cms_pkg::MODE_PRECOOL;
          press_latch_next = 1'b0;
          restart          = 1'b1;
        end else if (standby_timeout) begin
          mode_next = cms_pkg::MODE_OFF;
          restart   = 1'b1;
        end
      end
      cms_pkg::MODE_PRECOOL: begin
        if (latch_set) begin
          press_latch_next = 1'b1;
          restart          = 1'b1;
        end
        if (short_press) begin
          press_latch_next = 1'b0;
          mode_next        = cms_pkg::MODE_RUN;
          restart          = 1'b1;
        end else if (long_press) begin
          press_latch_next = 1'b0;
          mode_next        = cms_pkg::MODE_STANDBY;
          restart          = 1'b1;
        end
      end
      cms_pkg::MODE_RUN: begin
        if (!run_active) begin
          cycle_count_next = cycle_count + 16'd1;
          press_latch_next = 1'b0;
          mode_next        = cms_pkg::MODE_PRECOOL;
          restart          = 1'b1;
        end
      end
      default: ;
    endcase

    if (restart) begin
      elapsed_ms_next = 16'd0;
    end else if (elapsed_ms != cms_pkg::ELAPSED_MAX) begin
      elapsed_ms_next = elapsed_ms + 16'd1;
    end else begin
      elapsed_ms_next = elapsed_ms;
    end
  end

  // Outputs for this transaction
  always_comb begin
    result.pump_level     = 12'd0;
    result.rotation_level = 12'd0;
    result.cooler_level   = 12'd0;
    result.remaining_ms   = 16'd0;
    case (mode)
      cms_pkg::MODE_PRECOOL: begin
        if (warm) begin
          result.pump_level   = cfg.pump_duty;
          result.cooler_level = cfg.cooler_full_duty;
        end
      end
      cms_pkg::MODE_RUN: begin
        if (run_active) begin
          result.remaining_ms   = cfg.run_time_ms - elapsed_ms;
          result.pump_level     = cfg.pump_duty;
          result.rotation_level = cfg.rotation_duty;
          result.cooler_level   = warm ? cfg.cooler_full_duty : 12'd0;
        end
      end
      default: ;
    endcase
    result.mode_now      = mode_next;
    result.cycles_done   = cycle_count_next;
    result.sleep_request = (mode_next == cms_pkg::MODE_OFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cms_pkg::MODE_STANDBY;
      elapsed_ms  <= 16'd0;
      press_latch <= 1'b0;
      cycle_count <= 16'd0;
    end else if (step) begin
      mode        <= mode_next;
      elapsed_ms  <= elapsed_ms_next;
      press_latch <= press_latch_next;
      cycle_count <= cycle_count_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/chiller_mode_sequencer_top.sv
// Chiller mode sequencer: top level with handshake and result register.
// Depends on cms_pkg, cms_cfg_regs and cms_core.
`timescale 1ns / 1ps
`default_nettype none

// One input transaction per millisecond tick (temperature and button level)
// yields exactly one result transaction (mode, duty levels, remaining run
// time, completed-run count, sleep request). The block takes one transaction
// per clock while in_ready is high, and the result appears in the cycle after
// acceptance; the single result register sets both. in_ready stays high while
// the result register is empty or being drained, so back-to-back transactions
// flow at full rate. Off mode holds until reset. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
module chiller_mode_sequencer_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cms_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [cms_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire cms_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output cms_pkg::out_t                          out_data
);

  cms_pkg::cfg_t  cfg;
  cms_pkg::out_t  result;
  cms_pkg::mode_t mode;
  logic           step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  cms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cms_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cfg     (cfg),
    .in_data (in_data),
    .result  (result),
    .mode    (mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  // Registered result must agree with the state the core moved to
  a_mode_matches: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_data.mode_now == mode))
    else $error("result mode differs from core mode");

  a_remaining_only_in_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.remaining_ms != 16'd0)) |->
      (out_data.mode_now == cms_pkg::MODE_RUN))
    else $error("remaining time reported outside a run");

  a_off_absorbing: assert property (@(posedge clk) disable iff (rst)
    (mode == cms_pkg::MODE_OFF) |=> (mode == cms_pkg::MODE_OFF))
    else $error("left off mode without reset");

  a_sleep_means_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sleep_request == (out_data.mode_now == cms_pkg::MODE_OFF)))
    else $error("sleep request inconsistent with mode");
`endif

endmodule

`default_nettype wire
